// ===== rtl/core/tdfh_pkg.sv =====
// Shared constants, types and the microcode table of the factor histogram.
`timescale 1ns / 1ps
package tdfh_pkg;

  localparam int NumW       = 32;
  localparam int BinW       = 32;
  localparam int NumBins    = 34;
  localparam int BinAddrW   = $clog2(NumBins);
  localparam int CntW       = 6;
  localparam int DivStepW   = $clog2(NumW);
  localparam int PcW        = 4;
  localparam logic [31:0] LimitReset = 32'd50000000;
  localparam logic [31:0] LimitFloor = 32'd4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_HALVE,
    OP_SET_D3,
    OP_DIV_START,
    OP_STEP,
    OP_RD_CNT,
    OP_TALLY,
    OP_RD_BIN,
    OP_READ_RES,
    OP_SKIP_RES,
    OP_EMIT
  } tdfh_op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_READ,
    C_SKIP,
    C_EVEN,
    C_DIV_BUSY,
    C_D_GT_Q,
    C_OUT_BUSY
  } tdfh_cond_e;

  typedef struct packed {
    tdfh_op_e         op;
    tdfh_cond_e       cond;
    logic [PcW-1:0]   target;
  } tdfh_uword_t;

  typedef struct packed {
    logic in_valid;
    logic is_read;
    logic is_skip;
    logic n_even;
    logic div_busy;
    logic d_gt_q;
    logic out_busy;
  } tdfh_flags_t;

  localparam logic [PcW-1:0] PcWait    = 4'd0;
  localparam logic [PcW-1:0] PcHalve   = 4'd3;
  localparam logic [PcW-1:0] PcDiv     = 4'd5;
  localparam logic [PcW-1:0] PcDivWait = 4'd6;
  localparam logic [PcW-1:0] PcTally   = 4'd9;
  localparam logic [PcW-1:0] PcEmit    = 4'd11;
  localparam logic [PcW-1:0] PcRead    = 4'd13;
  localparam logic [PcW-1:0] PcSkip    = 4'd15;

  function automatic tdfh_uword_t micro_rom(input logic [PcW-1:0] pc);
    tdfh_uword_t w;
    case (pc)
      4'd0:    w = '{OP_LATCH,     C_NO_IN,    PcWait};
      4'd1:    w = '{OP_NOP,       C_READ,     PcRead};
      4'd2:    w = '{OP_NOP,       C_SKIP,     PcSkip};
      4'd3:    w = '{OP_HALVE,     C_EVEN,     PcHalve};
      4'd4:    w = '{OP_SET_D3,    C_NEVER,    PcWait};
      4'd5:    w = '{OP_DIV_START, C_NEVER,    PcWait};
      4'd6:    w = '{OP_NOP,       C_DIV_BUSY, PcDivWait};
      4'd7:    w = '{OP_NOP,       C_D_GT_Q,   PcTally};
      4'd8:    w = '{OP_STEP,      C_ALWAYS,   PcDiv};
      4'd9:    w = '{OP_RD_CNT,    C_NEVER,    PcWait};
      4'd10:   w = '{OP_TALLY,     C_NEVER,    PcWait};
      4'd11:   w = '{OP_EMIT,      C_OUT_BUSY, PcEmit};
      4'd12:   w = '{OP_NOP,       C_ALWAYS,   PcWait};
      4'd13:   w = '{OP_RD_BIN,    C_NEVER,    PcWait};
      4'd14:   w = '{OP_READ_RES,  C_ALWAYS,   PcEmit};
      4'd15:   w = '{OP_SKIP_RES,  C_ALWAYS,   PcEmit};
      default: w = '{OP_NOP,       C_ALWAYS,   PcWait};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/tdfh_in_if.sv =====
// Input channel: action, number and bin index with valid/ready.
`timescale 1ns / 1ps
interface tdfh_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] number;
  logic [5:0]  bin_index;

  modport source (output valid, action, number, bin_index, input ready);
  modport sink   (input valid, action, number, bin_index, output ready);
endinterface

// ===== rtl/core/tdfh_out_if.sv =====
// Result channel: factor count, skip flag and bin total with valid/ready.
`timescale 1ns / 1ps
interface tdfh_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  factor_count;
  logic        skipped;
  logic [31:0] bin_total;

  modport source (output valid, factor_count, skipped, bin_total, input ready);
  modport sink   (input valid, factor_count, skipped, bin_total, output ready);
endinterface

// ===== rtl/core/tdfh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tdfh_ram #(
  parameter int Width = 32,
  parameter int Depth = 34
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tdfh_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tdfh_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tdfh_pkg::NumW-1:0] dividend_i,
  input  logic [tdfh_pkg::NumW-1:0] divisor_i,
  output logic                     busy_o,
  output logic [tdfh_pkg::NumW-1:0] quo_o,
  output logic [tdfh_pkg::NumW-1:0] rem_o
);

  logic                          busy_q, busy_d;
  logic [tdfh_pkg::DivStepW-1:0] step_q, step_d;
  logic [tdfh_pkg::NumW-1:0]     quo_q, quo_d;
  logic [tdfh_pkg::NumW-1:0]     rem_q, rem_d;
  logic [tdfh_pkg::NumW-1:0]     dvs_q, dvs_d;
  logic [tdfh_pkg::NumW:0]       rem_sh;
  logic [tdfh_pkg::NumW:0]       diff;
  logic                          ge;

  assign rem_sh = {rem_q, quo_q[tdfh_pkg::NumW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = ~diff[tdfh_pkg::NumW];

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[tdfh_pkg::NumW-1:0] : rem_sh[tdfh_pkg::NumW-1:0];
      quo_d  = {quo_q[tdfh_pkg::NumW-2:0], ge};
      step_d = step_q + tdfh_pkg::DivStepW'(1);
      if (step_q == tdfh_pkg::DivStepW'(tdfh_pkg::NumW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/tdfh_seq.sv =====
// Microcode sequencer: step counter, control table and conditional jumps.
`timescale 1ns / 1ps
module tdfh_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tdfh_pkg::tdfh_flags_t flags_i,
  output tdfh_pkg::tdfh_op_e    op_o
);

  logic [tdfh_pkg::PcW-1:0] pc_q, pc_d;
  tdfh_pkg::tdfh_uword_t    uw;
  logic                     jump;

  assign uw = tdfh_pkg::micro_rom(pc_q);

  always_comb begin
    case (uw.cond)
      tdfh_pkg::C_NEVER:    jump = 1'b0;
      tdfh_pkg::C_ALWAYS:   jump = 1'b1;
      tdfh_pkg::C_NO_IN:    jump = ~flags_i.in_valid;
      tdfh_pkg::C_READ:     jump = flags_i.is_read;
      tdfh_pkg::C_SKIP:     jump = flags_i.is_skip;
      tdfh_pkg::C_EVEN:     jump = flags_i.n_even;
      tdfh_pkg::C_DIV_BUSY: jump = flags_i.div_busy;
      tdfh_pkg::C_D_GT_Q:   jump = flags_i.d_gt_q;
      tdfh_pkg::C_OUT_BUSY: jump = flags_i.out_busy;
      default:              jump = 1'b1;
    endcase
    pc_d = jump ? uw.target : pc_q + tdfh_pkg::PcW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tdfh_pkg::PcWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = uw.op;

endmodule

// ===== rtl/core/trial_division_factor_histogram.sv =====
// Top level: trial-division factor counter with a 34-bin tally histogram.
//
// Input channel in_i carries one transaction per request: action 0 factors
// number and bumps histogram bin [count]; action 1 reads bin bin_index.
// Result channel res_o returns exactly one transaction per request.
// cfg_we_i/cfg_wdata_i write upper_limit (values below 4 are taken as 4);
// write it only while no request is in flight.
// A number that is 0 or not below upper_limit is skipped without a tally.
// A factored number is halved while even and then goes through trial
// steps, a trial step being one odd-factor division or one divisor advance,
// each costing one pass of the radix-2 divider plus sequencer steps.
// One request is worked on at a time; the next is accepted only after the
// current result has been moved into the output register.
// Reset clears the histogram at once through per-bin valid flags and sets
// upper_limit to 50000000. When the receiver stalls, the result is held in
// the output register; a following request is still accepted and worked
// on, and waits at its own emit step until the register is free.
`timescale 1ns / 1ps
module trial_division_factor_histogram (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdfh_in_if.sink     in_i,
  tdfh_out_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  tdfh_pkg::tdfh_op_e    op;
  tdfh_pkg::tdfh_flags_t flags;

  logic [31:0]                   limit_q;
  logic                          action_q;
  logic [tdfh_pkg::NumW-1:0]     n_q;
  logic [5:0]                    bin_q;
  logic [tdfh_pkg::CntW-1:0]     cnt_q;
  logic [tdfh_pkg::NumW-1:0]     d_q;
  logic [tdfh_pkg::NumBins-1:0]  bin_valid_q;
  logic [tdfh_pkg::CntW-1:0]     res_count_q;
  logic                          res_skip_q;
  logic [tdfh_pkg::BinW-1:0]     res_total_q;
  logic                          out_valid_q;
  logic [5:0]                    out_count_q;
  logic                          out_skip_q;
  logic [31:0]                   out_total_q;

  logic                          div_busy;
  logic [tdfh_pkg::NumW-1:0]     quo;
  logic [tdfh_pkg::NumW-1:0]     rem;
  logic                          bin_in_range;
  logic                          out_busy;
  logic                          ram_re;
  logic                          ram_we;
  logic [tdfh_pkg::BinAddrW-1:0] ram_raddr;
  logic [tdfh_pkg::BinW-1:0]     ram_rdata;
  logic [tdfh_pkg::BinW-1:0]     old_total;
  logic [tdfh_pkg::BinW-1:0]     new_total;
  logic [tdfh_pkg::CntW-1:0]     cnt_inc;

  tdfh_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  tdfh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op == tdfh_pkg::OP_DIV_START),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .busy_o     (div_busy),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  tdfh_ram #(
    .Width (tdfh_pkg::BinW),
    .Depth (tdfh_pkg::NumBins)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (new_total),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign bin_in_range = (bin_q < 6'(tdfh_pkg::NumBins));
  assign out_busy     = out_valid_q & ~res_o.ready;
  assign ram_re       = (op == tdfh_pkg::OP_RD_CNT) ||
                        ((op == tdfh_pkg::OP_RD_BIN) && bin_in_range);
  assign ram_raddr    = (op == tdfh_pkg::OP_RD_BIN) ? bin_q : cnt_q;
  assign ram_we       = (op == tdfh_pkg::OP_TALLY);
  assign old_total    = bin_valid_q[cnt_q] ? ram_rdata : '0;
  assign new_total    = (old_total == '1) ? old_total
                                          : old_total + tdfh_pkg::BinW'(1);
  assign cnt_inc      = (cnt_q == tdfh_pkg::CntW'(tdfh_pkg::NumBins - 1))
                        ? cnt_q : cnt_q + tdfh_pkg::CntW'(1);

  assign flags.in_valid = in_i.valid;
  assign flags.is_read  = action_q;
  assign flags.is_skip  = (n_q == '0) || (n_q >= limit_q);
  assign flags.n_even   = (n_q != '0) && ~n_q[0];
  assign flags.div_busy = div_busy;
  assign flags.d_gt_q   = (d_q > quo);
  assign flags.out_busy = out_busy;

  assign in_i.ready = (op == tdfh_pkg::OP_LATCH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= tdfh_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= (cfg_wdata_i < tdfh_pkg::LimitFloor) ? tdfh_pkg::LimitFloor
                                                       : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      tdfh_pkg::OP_LATCH: begin
        if (in_i.valid) begin
          action_q <= in_i.action;
          n_q      <= in_i.number;
          bin_q    <= in_i.bin_index;
          cnt_q    <= tdfh_pkg::CntW'(2);
        end
      end
      tdfh_pkg::OP_HALVE: begin
        if (~n_q[0]) begin
          n_q   <= n_q >> 1;
          cnt_q <= cnt_inc;
        end
      end
      tdfh_pkg::OP_SET_D3: d_q <= tdfh_pkg::NumW'(3);
      tdfh_pkg::OP_STEP: begin
        if (rem == '0) begin
          n_q   <= quo;
          cnt_q <= cnt_inc;
        end else begin
          d_q <= d_q + tdfh_pkg::NumW'(2);
        end
      end
      tdfh_pkg::OP_TALLY: begin
        res_count_q <= cnt_q;
        res_skip_q  <= 1'b0;
        res_total_q <= new_total;
      end
      tdfh_pkg::OP_READ_RES: begin
        res_count_q <= '0;
        res_skip_q  <= 1'b0;
        res_total_q <= (bin_in_range && bin_valid_q[bin_q]) ? ram_rdata : '0;
      end
      tdfh_pkg::OP_SKIP_RES: begin
        res_count_q <= '0;
        res_skip_q  <= 1'b1;
        res_total_q <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_valid_q <= '0;
    end else if (ram_we) begin
      bin_valid_q[cnt_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((op == tdfh_pkg::OP_EMIT) && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((op == tdfh_pkg::OP_EMIT) && !out_busy) begin
      out_count_q <= res_count_q;
      out_skip_q  <= res_skip_q;
      out_total_q <= res_total_q[31:0];
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.factor_count = out_count_q;
  assign res_o.skipped      = out_skip_q;
  assign res_o.bin_total    = out_total_q;

  a_limit_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q >= tdfh_pkg::LimitFloor)
    else $error("upper limit below floor");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == tdfh_pkg::OP_DIV_START) |-> (!div_busy && d_q[0]))
    else $error("divider started while busy or with even divisor");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((op == tdfh_pkg::OP_TALLY) || (op == tdfh_pkg::OP_STEP)) |->
      (cnt_q <= tdfh_pkg::CntW'(tdfh_pkg::NumBins - 1)))
    else $error("factor count out of bin range");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((op == tdfh_pkg::OP_EMIT) && !out_busy) |=> out_valid_q)
    else $error("emitted result not presented");

  a_tally_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == tdfh_pkg::OP_TALLY) |=> bin_valid_q[$past(cnt_q)])
    else $error("tallied bin not marked valid");

endmodule
